// File: rtl/core/pbffa_pkg.sv
`timescale 1ns / 1ps

package pbffa_pkg;

  localparam int BYTES_W = 13;
  localparam int OFF_W   = 12;

  // six low pages reserved after reset
  localparam logic [63:0] RESET_MAP = 64'h3f;

  typedef struct packed {
    logic load;
    logic div_step;
    logic plan;
    logic scan_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic need_scan;
    logic hit;
    logic at_limit;
  } status_t;

endpackage

// File: rtl/core/pbffa_req_if.sv
`timescale 1ns / 1ps

interface pbffa_req_if;
  logic                        valid;
  logic                        ready;
  logic                        mode;
  logic [pbffa_pkg::BYTES_W-1:0] request_bytes;
  logic [pbffa_pkg::OFF_W-1:0]   byte_offset;
  logic                        offset_valid;

  modport source (
    output valid, mode, request_bytes, byte_offset, offset_valid,
    input  ready
  );
  modport sink (
    input  valid, mode, request_bytes, byte_offset, offset_valid,
    output ready
  );
endinterface

// File: rtl/core/pbffa_rsp_if.sv
`timescale 1ns / 1ps

interface pbffa_rsp_if;
  logic                      valid;
  logic                      ready;
  logic                      ok;
  logic [pbffa_pkg::OFF_W-1:0] alloc_offset;

  modport source (
    output valid, ok, alloc_offset,
    input  ready
  );
  modport sink (
    input  valid, ok, alloc_offset,
    output ready
  );
endinterface

// File: rtl/core/page_bitmap_first_fit_allocator.sv
`timescale 1ns / 1ps

// channel  dir  handshake      payload
// req      in   valid / ready  mode, request_bytes, byte_offset, offset_valid
// rsp      out  valid / ready  ok, alloc_offset
//
// each request is accepted, divided by the page size (reciprocal multiply)
// and planned; an allocate that fits the map then scans start pages from
// zero, one start page a cycle, until a run is free or the last start page,
// and the result is then loaded into the output register.
// reset is synchronous; it restores the map with the six low pages reserved.
// req is taken only between items; a stalled rsp holds the finished item back.

module page_bitmap_first_fit_allocator #(
  parameter int PAGE_COUNT = 64,
  parameter int PAGE_BYTES = 64
) (
  input logic        clk,
  input logic        rst,
  pbffa_req_if.sink  req,
  pbffa_rsp_if.source rsp
);

  pbffa_pkg::cmd_t    cmd;
  pbffa_pkg::status_t st;

  pbffa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .st        (st),
    .cmd       (cmd)
  );

  pbffa_dp #(
    .PAGE_COUNT (PAGE_COUNT),
    .PAGE_BYTES (PAGE_BYTES)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .st              (st),
    .in_mode         (req.mode),
    .in_bytes        (req.request_bytes),
    .in_offset       (req.byte_offset),
    .in_offset_valid (req.offset_valid),
    .out_ok          (rsp.ok),
    .out_offset      (rsp.alloc_offset)
  );

  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load, cmd.div_step, cmd.plan, cmd.scan_step, cmd.out_load}))
    else $error("more than one datapath command at once");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> (!req.ready && cmd.div_step))
    else $error("request accepted but division did not start");

  a_fail_zero_offset: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && !rsp.ok) |-> (rsp.alloc_offset == '0))
    else $error("failed result carries a nonzero offset");

  a_scan_ends: assert property (@(posedge clk) disable iff (rst)
    (cmd.scan_step && (st.hit || st.at_limit)) |=> !cmd.scan_step)
    else $error("scan continued past a hit or its last start page");

endmodule

// File: rtl/core/pbffa_ctrl.sv
`timescale 1ns / 1ps

module pbffa_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  pbffa_pkg::status_t st,
  output pbffa_pkg::cmd_t    cmd
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_DIV   = 5'b00010,
    S_PLAN  = 5'b00100,
    S_SCAN  = 5'b01000,
    S_WRITE = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        state_next   = S_PLAN;
      end
      S_PLAN: begin
        cmd.plan   = 1'b1;
        state_next = st.need_scan ? S_SCAN : S_WRITE;
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (st.hit || st.at_limit) state_next = S_WRITE;
      end
      S_WRITE: begin
        // wait for the output register to free up
        if (!out_valid || out_ready) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// File: rtl/core/pbffa_dp.sv
`timescale 1ns / 1ps

module pbffa_dp #(
  parameter int PAGE_COUNT = 64,
  parameter int PAGE_BYTES = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  pbffa_pkg::cmd_t               cmd,
  output pbffa_pkg::status_t            st,
  input  logic                          in_mode,
  input  logic [pbffa_pkg::BYTES_W-1:0] in_bytes,
  input  logic [pbffa_pkg::OFF_W-1:0]   in_offset,
  input  logic                          in_offset_valid,
  output logic                          out_ok,
  output logic [pbffa_pkg::OFF_W-1:0]   out_offset
);

  // numerator width: bytes + PAGE_BYTES - 1 stays below 2^14
  localparam int NW = pbffa_pkg::BYTES_W + 1;
  localparam int SI = $clog2(PAGE_COUNT);

  // floor(n / PAGE_BYTES) == (n * RECIP) >> KS for every n below 2^NW
  localparam int LG = $clog2(PAGE_BYTES);
  localparam int KS = NW + LG;
  localparam int MW = NW + 2;
  localparam int PW = NW + MW;
  localparam logic [MW-1:0] RECIP =
    MW'(((64'd1 << KS) + 64'(PAGE_BYTES) - 64'd1) / 64'(PAGE_BYTES));

  logic                  mode_q;
  logic                  valid_q;
  logic [NW-1:0]         bnum, bq;
  logic [NW-1:0]         onum, oq;
  logic [PAGE_COUNT-1:0] page_map;
  logic [PAGE_COUNT-1:0] want;
  logic [SI-1:0]         start;
  logic [SI-1:0]         limit;
  logic                  res_ok;
  logic [pbffa_pkg::OFF_W-1:0] res_off;

  // division by the page size as a reciprocal multiply
  logic [PW-1:0] b_prod, o_prod;

  assign b_prod = PW'(bnum) * PW'(RECIP);
  assign o_prod = PW'(onum) * PW'(RECIP);

  logic [NW-1:0]         pages;
  logic [NW-1:0]         lim_full;
  logic                  pages_fit;
  logic [PAGE_COUNT-1:0] want_init;
  logic [PAGE_COUNT-1:0] free_mask;
  logic [NW:0]           free_end;
  logic                  free_ok;

  assign pages     = bq;
  assign pages_fit = (pages != '0) && (pages <= NW'(PAGE_COUNT));
  assign lim_full  = NW'(PAGE_COUNT) - pages;
  assign free_end  = {1'b0, oq} + {1'b0, pages};
  assign free_ok   = valid_q && (pages != '0);

  always_comb begin
    for (int i = 0; i < PAGE_COUNT; i++) begin
      want_init[i] = (NW'(i) < pages);
      // pages at or above the top of the map drop out here
      free_mask[i] = (NW'(i) >= oq) && ((NW + 1)'(i) < free_end);
    end
  end

  logic hit;
  assign hit = ~|(page_map & want);

  assign st.need_scan = !mode_q && pages_fit;
  assign st.hit       = hit;
  assign st.at_limit  = (start == limit);

  always_ff @(posedge clk) begin
    if (rst) begin
      page_map <= PAGE_COUNT'(pbffa_pkg::RESET_MAP);
    end else begin
      if (cmd.plan && mode_q && free_ok) begin
        page_map <= page_map & ~free_mask;
      end else if (cmd.scan_step && hit) begin
        page_map <= page_map | want;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_q  <= in_mode;
      valid_q <= in_offset_valid;
      bnum    <= NW'(in_bytes) + NW'(PAGE_BYTES - 1);
      onum    <= NW'(in_offset);
    end
    if (cmd.div_step) begin
      bq <= NW'(b_prod >> KS);
      oq <= NW'(o_prod >> KS);
    end
    if (cmd.plan) begin
      res_ok  <= mode_q && free_ok;
      res_off <= '0;
      want    <= want_init;
      start   <= '0;
      limit   <= lim_full[SI-1:0];
    end
    if (cmd.scan_step) begin
      if (hit) begin
        res_ok  <= 1'b1;
        res_off <= pbffa_pkg::OFF_W'(int'(start) * PAGE_BYTES);
      end else begin
        want  <= {want[PAGE_COUNT-2:0], 1'b0};
        start <= start + SI'(1);
      end
    end
    if (cmd.out_load) begin
      out_ok     <= res_ok;
      out_offset <= res_off;
    end
  end

endmodule

// File: dv/alloc_checker.sv
`timescale 1ns / 1ps

package alloc_tb_pkg;

  localparam int PAGE_COUNT = 64;
  localparam int PAGE_BYTES = 64;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_e;

endpackage

module alloc_checker (
  input  logic  clk,
  input  logic  rst,
  pbffa_req_if  req,
  pbffa_rsp_if  rsp,
  output int    fail_count,
  output int    pending
);

  import pbffa_pkg::*;
  import alloc_tb_pkg::*;

  typedef struct packed {
    logic            ok;
    logic [OFF_W-1:0] offset;
  } grant_t;

  logic [63:0] shadow_map;
  grant_t      grants_due[$];

  function automatic logic [63:0] page_run(input int n);
    if (n <= 0) begin
      return '0;
    end
    if (n >= 64) begin
      return '1;
    end
    return (64'd1 << n) - 64'd1;
  endfunction

  // first fit over the shadow map; updates the map as the block should
  function automatic grant_t predict_grant(input op_e op, input logic [BYTES_W-1:0] nbytes,
                                           input logic [OFF_W-1:0] off, input logic off_ok);
    grant_t      g;
    int          pages;
    int          first;
    int          cnt;
    logic        found;
    logic [63:0] run;
    g = '0;
    found = 1'b0;
    pages = (int'(nbytes) + PAGE_BYTES - 1) / PAGE_BYTES;
    if (op == OP_ALLOC) begin
      if (pages > 0 && pages <= PAGE_COUNT) begin
        run = page_run(pages);
        for (int s = 0; s + pages <= PAGE_COUNT; s++) begin
          if (!found && (shadow_map & (run << s)) == 64'd0) begin
            found = 1'b1;
            shadow_map = shadow_map | (run << s);
            g.ok = 1'b1;
            g.offset = OFF_W'(s * PAGE_BYTES);
          end
        end
      end
    end else if (off_ok && pages > 0) begin
      g.ok = 1'b1;
      first = int'(off) / PAGE_BYTES;
      // pages past the top of the map are dropped
      if (first < PAGE_COUNT) begin
        cnt = (pages < PAGE_COUNT - first) ? pages : PAGE_COUNT - first;
        shadow_map = shadow_map & ~(page_run(cnt) << first);
      end
    end
    return g;
  endfunction

  initial fail_count = 0;

  always @(posedge clk) begin
    grant_t want;
    if (rst) begin
      shadow_map = RESET_MAP;
      grants_due.delete();
    end else begin
      if (req.valid && req.ready) begin
        grants_due.push_back(predict_grant(op_e'(req.mode), req.request_bytes,
                                           req.byte_offset, req.offset_valid));
      end
      if (rsp.valid && rsp.ready) begin
        if (grants_due.size() == 0) begin
          $error("unexpected result beat: ok=%0b alloc_offset=%0d", rsp.ok, rsp.alloc_offset);
          fail_count++;
        end else begin
          want = grants_due.pop_front();
          if (rsp.ok !== want.ok) begin
            $error("ok: expected %0b, got %0b", want.ok, rsp.ok);
            fail_count++;
          end
          if (rsp.alloc_offset !== want.offset) begin
            $error("alloc_offset: expected %0d, got %0d", want.offset, rsp.alloc_offset);
            fail_count++;
          end
        end
      end
    end
    pending <= grants_due.size();
  end

endmodule

// File: dv/testbench.sv
`timescale 1ns / 1ps

module testbench;

  import pbffa_pkg::*;
  import alloc_tb_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int HOLD_CYCLES = 400;
  localparam int RANDOM_ITEMS = 2000;
  localparam int PHASE_ITEMS = RANDOM_ITEMS / 4;
  localparam int MAP_BYTES = PAGE_COUNT * PAGE_BYTES;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   idle_pct = 0;
  int   stall_pct = 0;
  int   hold_asks = 0;
  int   cycles = 0;
  int   fail_count;
  int   pending;

  pbffa_req_if req_ch ();
  pbffa_rsp_if rsp_ch ();

  page_bitmap_first_fit_allocator #(
    .PAGE_COUNT(PAGE_COUNT),
    .PAGE_BYTES(PAGE_BYTES)
  ) uut (
    .clk(clk),
    .rst(rst),
    .req(req_ch.sink),
    .rsp(rsp_ch.source)
  );

  alloc_checker grant_check (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch),
    .fail_count(fail_count),
    .pending(pending)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // result side: random stalls, plus a long hold-off when asked
  initial begin
    int hold_left;
    int holds_taken;
    hold_left = 0;
    holds_taken = 0;
    rsp_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else if (holds_taken != hold_asks) begin
        holds_taken++;
        hold_left = HOLD_CYCLES;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  task automatic send_req(input op_e op, input logic [BYTES_W-1:0] nbytes,
                          input logic [OFF_W-1:0] off, input logic off_ok);
    while ($urandom_range(0, 99) < idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid         <= 1'b1;
    req_ch.mode          <= op;
    req_ch.request_bytes <= nbytes;
    req_ch.byte_offset   <= off;
    req_ch.offset_valid  <= off_ok;
    do @(posedge clk); while (!req_ch.ready);
  endtask

  task automatic drain_results();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // mostly small allocs and page-aligned frees so the map churns near full
  task automatic random_item();
    int                 pick;
    logic [BYTES_W-1:0] nb;
    logic [OFF_W-1:0]   off;
    pick = $urandom_range(0, 99);
    off = OFF_W'($urandom);
    if (pick < 55) begin
      case ($urandom_range(0, 19))
        0:       nb = BYTES_W'($urandom);
        1:       nb = BYTES_W'($urandom_range(0, MAP_BYTES));
        2:       nb = BYTES_W'($urandom_range(MAP_BYTES / 2, MAP_BYTES));
        default: nb = BYTES_W'($urandom_range(1, 8 * PAGE_BYTES));
      endcase
      send_req(OP_ALLOC, nb, off, 1'($urandom_range(0, 1)));
    end else if (pick < 57) begin
      send_req(OP_FREE, BYTES_W'(MAP_BYTES), '0, 1'b1);
    end else if (pick < 90) begin
      off = OFF_W'($urandom_range(0, PAGE_COUNT - 1) * PAGE_BYTES);
      nb = BYTES_W'($urandom_range(1, 8 * PAGE_BYTES));
      send_req(OP_FREE, nb, off, 1'b1);
    end else begin
      send_req(OP_FREE, BYTES_W'($urandom), off, 1'($urandom_range(0, 1)));
    end
  endtask

  initial begin
    req_ch.valid = 1'b0;
    req_ch.mode = OP_ALLOC;
    req_ch.request_bytes = '0;
    req_ch.byte_offset = '0;
    req_ch.offset_valid = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // edge cases against a known map
    send_req(OP_ALLOC, 13'd0, 12'hfff, 1'b1);
    send_req(OP_ALLOC, 13'd1, 12'd0, 1'b0);
    send_req(OP_ALLOC, 13'd64, 12'd0, 1'b0);
    send_req(OP_ALLOC, 13'd65, 12'hfff, 1'b1);
    send_req(OP_ALLOC, 13'd4096, 12'd0, 1'b0);
    send_req(OP_ALLOC, 13'h1fff, 12'd0, 1'b0);
    send_req(OP_FREE, 13'd64, 12'd384, 1'b0);
    send_req(OP_FREE, 13'd0, 12'd384, 1'b1);
    send_req(OP_FREE, 13'd4096, 12'd0, 1'b1);
    send_req(OP_ALLOC, 13'd4096, 12'd0, 1'b0);
    send_req(OP_ALLOC, 13'd1, 12'd0, 1'b0);
    send_req(OP_FREE, 13'h1fff, 12'd4032, 1'b1);
    send_req(OP_FREE, 13'd1, 12'd100, 1'b1);
    send_req(OP_ALLOC, 13'd64, 12'd0, 1'b0);
    send_req(OP_FREE, 13'd128, 12'hfff, 1'b1);
    send_req(OP_FREE, 13'd4096, 12'd0, 1'b1);
    send_req(OP_ALLOC, 13'd2048, 12'd0, 1'b0);
    send_req(OP_ALLOC, 13'd2048, 12'd0, 1'b0);
    send_req(OP_ALLOC, 13'd64, 12'd0, 1'b0);
    send_req(OP_FREE, 13'd640, 12'd1024, 1'b1);
    send_req(OP_ALLOC, 13'd704, 12'd0, 1'b0);
    send_req(OP_ALLOC, 13'd640, 12'd0, 1'b0);
    send_req(OP_FREE, 13'd4096, 12'd0, 1'b1);

    for (int ph = 0; ph < 4; ph++) begin
      // sender waits for every outstanding result between phases
      drain_results();
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 53; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 53; end
        default: begin idle_pct = 24; stall_pct = 24; end
      endcase
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (ph == 0 && i == 100) begin
          hold_asks++;
        end
        if (ph == 3 && i == 200) begin
          hold_asks++;
        end
        random_item();
      end
    end

    drain_results();
    repeat (100) @(posedge clk);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
